>>> sv/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEFAULT_DEPTH = 16;

    localparam int ID_W   = 16;
    localparam int PRIO_W = 7;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // request kinds
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ_SCAN,
        S_ENQ_LAST,
        S_DEQ_HEAD,
        S_DEQ_SHIFT
    } state_t;

endpackage

>>> sv/spq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_mem
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spq_mem #(
    parameter int DEPTH = spq_pkg::DEFAULT_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  spq_pkg::entry_t          wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output spq_pkg::entry_t          rdata
);
    import spq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: walks the sorted slot memory one entry per cycle to insert
// (scanning from the tail) or to remove the front (shifting forward).
// ----------------------------------------------------------------------------
module spq_ctrl #(
    parameter int DEPTH = spq_pkg::DEFAULT_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic [spq_pkg::ID_W-1:0]    proc_id,
    input  logic [spq_pkg::PRIO_W-1:0]  prio,
    output logic                        done,
    output logic [spq_pkg::STAT_W-1:0]  status,
    output logic [spq_pkg::ID_W-1:0]    out_id,
    output logic [spq_pkg::PRIO_W-1:0]  out_prio,
    output logic [spq_pkg::OCC_W-1:0]   occupancy,
    output logic                        mem_we,
    output logic [$clog2(DEPTH)-1:0]    mem_waddr,
    output spq_pkg::entry_t             mem_wdata,
    output logic [$clog2(DEPTH)-1:0]    mem_raddr,
    input  spq_pkg::entry_t             mem_rdata
);
    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [ID_W-1:0]     req_id_reg, req_id_next;
    logic [PRIO_W-1:0]   req_prio_reg, req_prio_next;
    logic                done_reg, done_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [ID_W-1:0]     out_id_reg, out_id_next;
    logic [PRIO_W-1:0]   out_prio_reg, out_prio_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        req_id_reg   <= req_id_next;
        req_prio_reg <= req_prio_next;
        status_reg   <= status_next;
        out_id_reg   <= out_id_next;
        out_prio_reg <= out_prio_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        req_id_next   = req_id_reg;
        req_prio_next = req_prio_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        out_id_next   = out_id_reg;
        out_prio_next = out_prio_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '{id: req_id_reg, prio: req_prio_reg};
        mem_raddr     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_id_next   = proc_id;
                    req_prio_next = prio;
                    out_id_next   = '0;
                    out_prio_next = '0;
                    if (req_type == REQ_ENQ)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            mem_we      = 1'b1;
                            mem_wdata   = '{id: proc_id, prio: prio};
                            count_next  = count_reg + CW'(1);
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end
                        else
                        begin
                            mem_raddr  = AW'(count_reg - CW'(1));
                            idx_next   = AW'(count_reg - CW'(1));
                            state_next = S_ENQ_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_DEQ_HEAD;
                        end
                    end
                end
            end

            // tail-first scan: every lower-priority entry moves back one slot
            S_ENQ_SCAN:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg + AW'(1);
                if (mem_rdata.prio >= req_prio_reg)
                begin
                    count_next  = count_reg + CW'(1);
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_wdata = mem_rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = S_ENQ_LAST;
                    end
                    else
                    begin
                        mem_raddr = idx_reg - AW'(1);
                        idx_next  = idx_reg - AW'(1);
                    end
                end
            end

            // new word lands at the front
            S_ENQ_LAST:
            begin
                mem_we      = 1'b1;
                count_next  = count_reg + CW'(1);
                done_next   = 1'b1;
                status_next = ST_OK;
                state_next  = S_IDLE;
            end

            S_DEQ_HEAD:
            begin
                out_id_next   = mem_rdata.id;
                out_prio_next = mem_rdata.prio;
                if (count_reg == CW'(1))
                begin
                    count_next  = count_reg - CW'(1);
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_raddr  = AW'(1);
                    idx_next   = AW'(1);
                    state_next = S_DEQ_SHIFT;
                end
            end

            S_DEQ_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg - AW'(1);
                mem_wdata = mem_rdata;
                if ((CW'(idx_reg) + CW'(1)) == count_reg)
                begin
                    count_next  = count_reg - CW'(1);
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_raddr = idx_reg + AW'(1);
                    idx_next  = idx_reg + AW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign out_id    = out_id_reg;
    assign out_prio  = out_prio_reg;
    assign occupancy = OCC_W'(count_reg);

endmodule

>>> sv/stable_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Priority queue of process entries, highest priority first, FIFO on ties.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a word (req_type, proc_id, prio) is taken at a clock edge
//   with start high and busy low. req_type 0 enqueues, 1 dequeues the front.
//   Result channel: done pulses for one cycle with status, out_id, out_prio
//   and occupancy (entries held after the request). The receiver has no
//   back-pressure; the result must be captured in that cycle.
//   Entries live in a sorted slot memory with one read and one write port.
//   Enqueue walks from the tail, moving each lower-priority entry back one
//   slot per cycle; dequeue reads the front and shifts the rest forward one
//   slot per cycle. Refused requests (full, empty) and an enqueue into an
//   empty queue finish straight from idle without a walk; for the others
//   the read-modify-write walk over the single memory sets the time from
//   acceptance to done. Requests are handled one at a time; during a walk
//   busy stays high and drops in the cycle done is shown, so the next
//   request may start then.
//   Reset empties the queue; slot contents need no clearing.
// ----------------------------------------------------------------------------
module stable_priority_queue_core #(
    parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic [spq_pkg::ID_W-1:0]    proc_id,
    input  logic [spq_pkg::PRIO_W-1:0]  prio,
    output logic                        done,
    output logic [spq_pkg::STAT_W-1:0]  status,
    output logic [spq_pkg::ID_W-1:0]    out_id,
    output logic [spq_pkg::PRIO_W-1:0]  out_prio,
    output logic [spq_pkg::OCC_W-1:0]   occupancy
);
    import spq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;

    spq_ctrl #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .proc_id   (proc_id),
        .prio      (prio),
        .done      (done),
        .status    (status),
        .out_id    (out_id),
        .out_prio  (out_prio),
        .occupancy (occupancy),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    spq_mem #(
        .DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // an accepted word either starts a walk or finishes on the next edge
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted word neither busy nor done");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while still busy");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> out_id == '0 && out_prio == '0)
        else $error("error result carries payload");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_EMPTY |-> occupancy == '0)
        else $error("empty status with nonzero occupancy");

endmodule

>>> tb/sv/tb_stable_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue_core
// Self-checking bench for the stable priority queue core: directed requests
// cover empty, full, tied and out-of-range priorities, then biased random
// traffic with bursty requests checks every result against a local sorted
// list model of the queue.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue_core;
    import spq_pkg::*;

    localparam int DEPTH       = DEFAULT_DEPTH;
    localparam int RAND_WORDS  = 1550;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]  occ;
    } result_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                req_type;
    logic [ID_W-1:0]     proc_id;
    logic [PRIO_W-1:0]   prio;
    logic                done;
    logic [STAT_W-1:0]   status;
    logic [ID_W-1:0]     out_id;
    logic [PRIO_W-1:0]   out_prio;
    logic [OCC_W-1:0]    occupancy;

    // local copy of the sorted slots, front at index 0
    logic [ID_W-1:0]     model_ids[DEPTH];
    logic [PRIO_W-1:0]   model_prios[DEPTH];
    int                  model_count;

    result_t             pending[$];
    int                  errors;
    int                  cycle_count;
    int                  n_ok;
    int                  n_full;
    int                  n_empty;
    int                  n_words;

    stable_priority_queue_core #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .proc_id(proc_id),
        .prio(prio),
        .done(done),
        .status(status),
        .out_id(out_id),
        .out_prio(out_prio),
        .occupancy(occupancy)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // work out the result of one accepted request and update the list
    task automatic queue_predict(input logic rt, input logic [ID_W-1:0] id,
                                 input logic [PRIO_W-1:0] pr);
        result_t r;
        int      pos;
        r = '0;
        if (rt == REQ_ENQ)
        begin
            if (model_count >= DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < model_count && model_prios[pos] >= pr)
                    pos++;
                for (int i = model_count; i > pos; i--)
                begin
                    model_ids[i]   = model_ids[i-1];
                    model_prios[i] = model_prios[i-1];
                end
                model_ids[pos]   = id;
                model_prios[pos] = pr;
                model_count++;
                r.status = ST_OK;
            end
        end
        else if (model_count == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            r.status = ST_OK;
            r.id     = model_ids[0];
            r.prio   = model_prios[0];
            for (int i = 1; i < model_count; i++)
            begin
                model_ids[i-1]   = model_ids[i];
                model_prios[i-1] = model_prios[i];
            end
            model_count--;
        end
        r.occ = model_count[OCC_W-1:0];
        pending.push_back(r);
    endtask

    // drive one word and hold it until the core takes it; start stays high
    task automatic send_word(input logic rt, input logic [ID_W-1:0] id,
                             input logic [PRIO_W-1:0] pr);
        @(negedge clk);
        start    = 1'b1;
        req_type = rt;
        proc_id  = id;
        prio     = pr;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        n_words++;
        queue_predict(rt, id, pr);
    endtask

    task automatic idle_for(input int n);
        @(negedge clk);
        start    = 1'b0;
        req_type = 1'($urandom_range(0, 1));
        proc_id  = 16'($urandom);
        prio     = 7'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        start = 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // result checker: done is a one-cycle strobe with no back-pressure
    always @(posedge clk)
    begin
        result_t got;
        result_t exp;
        if (rst_n && done)
        begin
            got = {status, out_id, out_prio, occupancy};
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d id=%0d prio=%0d occ=%0d",
                         $time, status, out_id, out_prio, occupancy);
                errors++;
            end
            else
            begin
                exp = pending.pop_front();
                if (got !== exp)
                begin
                    $display("%0t: mismatch expected status=%0d id=%0d prio=%0d occ=%0d",
                             $time, exp.status, exp.id, exp.prio, exp.occ);
                    $display("%0t:          actual   status=%0d id=%0d prio=%0d occ=%0d",
                             $time, got.status, got.id, got.prio, got.occ);
                    errors++;
                end
                case (exp.status)
                    ST_FULL:  n_full++;
                    ST_EMPTY: n_empty++;
                    default:  n_ok++;
                endcase
            end
        end
    end

    task automatic test_empty_dequeue();
        send_word(REQ_DEQ, 16'hFFFF, 7'h7F);
        send_word(REQ_DEQ, 16'h0000, 7'h00);
    endtask

    // fill with extremes, ties and priorities above 100, then overflow once
    task automatic test_fill_to_full();
        logic [PRIO_W-1:0] prios[DEPTH];
        prios = '{7'd50, 7'd50, 7'd0, 7'd100, 7'd127, 7'd100, 7'd50, 7'd0,
                  7'd101, 7'd64, 7'd63, 7'd1, 7'd100, 7'd127, 7'd0, 7'd50};
        for (int i = 0; i < DEPTH; i++)
            send_word(REQ_ENQ,
                      (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'(32'h1000 + i),
                      prios[i]);
        send_word(REQ_ENQ, 16'hA5A5, 7'd100);
    endtask

    task automatic test_partial_drain();
        repeat (4) send_word(REQ_DEQ, 16'($urandom), 7'($urandom));
    endtask

    task automatic test_random_traffic();
        int                left;
        int                burst;
        int                enq_pct;
        int                sel;
        logic              rt;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] pr;
        left  = RAND_WORDS;
        burst = 0;
        while (left > 0)
        begin
            // epochs biased toward filling, draining or mixing the queue
            case ($urandom_range(0, 3))
                0:       enq_pct = 20;
                1:       enq_pct = 50;
                2:       enq_pct = 80;
                default: enq_pct = 95;
            endcase
            for (int k = $urandom_range(20, 80); k > 0 && left > 0; k--)
            begin
                if (burst == 0)
                begin
                    idle_for($urandom_range(1, 6));
                    burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                        : $urandom_range(1, 12);
                end
                rt  = ($urandom_range(1, 100) <= enq_pct) ? REQ_ENQ : REQ_DEQ;
                sel = $urandom_range(0, 19);
                if (sel < 5)
                    pr = ($urandom_range(0, 2) == 0) ? 7'd0 :
                         ($urandom_range(0, 1) == 0) ? 7'd50 : 7'd100;
                else if (sel < 7)
                    pr = 7'($urandom_range(101, 127));
                else
                    pr = 7'($urandom_range(0, 100));
                sel = $urandom_range(0, 15);
                id  = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : 16'($urandom);
                send_word(rt, id, pr);
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) == 0)
                wait_drain();
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_ENQ;
        proc_id     = '0;
        prio        = '0;
        errors      = 0;
        cycle_count = 0;
        n_ok        = 0;
        n_full      = 0;
        n_empty     = 0;
        n_words     = 0;
        model_count = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            model_ids[i]   = '0;
            model_prios[i] = '0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_empty_dequeue();
        test_fill_to_full();
        test_partial_drain();
        // sender holds off until the core has answered everything
        wait_drain();
        test_random_traffic();

        wait_drain();
        repeat (DEPTH + 4) @(posedge clk);
        if (pending.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending.size());
            errors += pending.size();
        end
        $display("Sent %0d request words; results: %0d ok, %0d refused full, %0d empty",
                 n_words, n_ok, n_full, n_empty);
        $display("Traffic mixed ties, priorities above 100 and fill/drain epochs");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> stable_priority_queue_core.f
sv/spq_pkg.sv
sv/spq_mem.sv
sv/spq_ctrl.sv
sv/stable_priority_queue_core.sv
tb/sv/tb_stable_priority_queue_core.sv
